// ===== rtl/krr_pkg.sv =====
// ============================================================================
// krr_pkg: shared types and constants of the keyed range random block
// Holds the hash constants, register map and sequencer state types.
// ============================================================================
package krr_pkg;

   // Hash finalizer constants
   localparam logic [63:0] GOLDEN     = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [63:0] MULT_A     = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [63:0] MULT_B     = 64'h94d0_49bb_1331_11eb;
   localparam logic [63:0] FRAME_SALT = 64'h0000_0000_0123_4567;

   // Register port geometry and register indexes (address bit 3 selects)
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 64;
   localparam logic REG_OBJECT_ID     = 1'b0;
   localparam logic REG_DEFAULT_FRAME = 1'b1;

   // Main sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRE,
      ST_MUL_A,
      ST_MUL_B,
      ST_DIV,
      ST_SUM
   } seq_state_type;

   // Which hash pass the sequencer is on
   typedef enum logic [1:0] {
      PH_SEED,
      PH_FRAME,
      PH_COUNT,
      PH_FINAL
   } hash_phase_type;

   // Partial product steps of the 64-bit multiplier
   typedef enum logic [1:0] {
      MUL_IDLE,
      MUL_LL,
      MUL_HL,
      MUL_LH
   } mul_step_type;

endpackage

// ===== rtl/krr_mul.sv =====
// ============================================================================
// krr_mul: iterative 64x64 multiplier, low 64 bits of the product
// One 32x32 multiplier builds the product from three partial products.
// ============================================================================
module krr_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] product
);

   krr_pkg::mul_step_type step_ff, step_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;
   logic        done_ff, done_in;
   logic [31:0] mul_x;
   logic [31:0] mul_y;
   logic [63:0] pp;

   // Pick the partial product operands for this step
   always_comb begin
      case (step_ff)
         krr_pkg::MUL_HL: begin
            mul_x = a_ff[63:32];
            mul_y = b_ff[31:0];
         end
         krr_pkg::MUL_LH: begin
            mul_x = a_ff[31:0];
            mul_y = b_ff[63:32];
         end
         default: begin
            mul_x = a_ff[31:0];
            mul_y = b_ff[31:0];
         end
      endcase
   end

   assign pp = mul_x * mul_y;

   // Advance through the steps and accumulate
   always_comb begin
      step_in = step_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      case (step_ff)
         krr_pkg::MUL_IDLE: begin
            if (start) begin
               a_in    = op_a;
               b_in    = op_b;
               step_in = krr_pkg::MUL_LL;
            end
         end
         krr_pkg::MUL_LL: begin
            acc_in  = pp;
            step_in = krr_pkg::MUL_HL;
         end
         krr_pkg::MUL_HL: begin
            acc_in  = acc_ff + {pp[31:0], 32'h0};
            step_in = krr_pkg::MUL_LH;
         end
         krr_pkg::MUL_LH: begin
            acc_in  = acc_ff + {pp[31:0], 32'h0};
            done_in = 1'b1;
            step_in = krr_pkg::MUL_IDLE;
         end
         default: begin
            step_in = krr_pkg::MUL_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= krr_pkg::MUL_IDLE;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   // Operands and accumulator
   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== rtl/krr_div.sv =====
// ============================================================================
// krr_div: serial 64-bit modulo unit
// Restoring division, one dividend bit per cycle; returns the remainder.
// ============================================================================
module krr_div #(
   parameter int DIV_WIDTH = 33
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [63:0]          dividend,
   input  logic [DIV_WIDTH-1:0] divisor,
   output logic                 done,
   output logic [DIV_WIDTH-1:0] remainder
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic [63:0]          dvd_ff, dvd_in;
   logic [DIV_WIDTH-1:0] dsr_ff, dsr_in;
   logic [DIV_WIDTH-1:0] rem_ff, rem_in;
   logic [DIV_WIDTH:0]   trial;
   logic [DIV_WIDTH+1:0] diff;

   // Shift in the next dividend bit and try the subtract
   assign trial = {rem_ff, dvd_ff[63]};
   assign diff  = {1'b0, trial} - {2'b00, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (busy_ff) begin
         dvd_in = {dvd_ff[62:0], 1'b0};
         cnt_in = cnt_ff + 6'd1;
         // keep the difference unless it borrowed
         if (diff[DIV_WIDTH+1]) begin
            rem_in = trial[DIV_WIDTH-1:0];
         end else begin
            rem_in = diff[DIV_WIDTH-1:0];
         end
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/keyed_range_random_top.sv =====
// ============================================================================
// keyed_range_random_top: keyed hash range random generator
// Hashes seed, frame and call counter with a 64-bit finalizer and reduces
// the hash into the inclusive range of two signed bounds.
// ============================================================================
//
//   channel  handshake              payload
//   -------  ---------------------  ------------------------------------------
//   req      req_valid/req_ready    bounds, seed flag and seed, frame flag/frame
//   rsp      rsp_valid/rsp_ready    rsp_random_value
//   csr      csr_psel/csr_penable   object_id 64-bit, default_frame 32-bit
//
// An item without an explicit seed takes an extra hash pass over the call counter.
// Each hash pass runs on the shared 32x32 multiplier (three partial products per
// 64-bit multiply), and the final modulo runs in the serial divider.
// req_ready is high only while the sequencer is idle.
// Reset clears the sequencer, call counter and registers. A result waits in
// the output register while the next transaction is already being worked on.
//
module keyed_range_random_top #(
   parameter int COUNTER_WIDTH = 32,
   parameter int VALUE_WIDTH   = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [VALUE_WIDTH-1:0]       req_low_bound,
   input  logic signed [VALUE_WIDTH-1:0]       req_high_bound,
   input  logic                                req_use_seed,
   input  logic signed [63:0]                  req_seed_value,
   input  logic                                req_has_frame,
   input  logic signed [31:0]                  req_frame_value,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [VALUE_WIDTH-1:0]       rsp_random_value,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [krr_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [krr_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [krr_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);

   localparam int SPAN_WIDTH = VALUE_WIDTH + 1;

   krr_pkg::seq_state_type  state_ff, state_in;
   krr_pkg::hash_phase_type phase_ff, phase_in;

   logic [63:0]              object_id_ff, object_id_in;
   logic [31:0]              frame_reg_ff, frame_reg_in;
   logic [COUNTER_WIDTH-1:0] cnt_ff, cnt_in;
   logic                     seeded_ff, seeded_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [63:0]              z_ff, z_in;
   logic [63:0]              fr_ff, fr_in;
   logic [63:0]              hold_ff, hold_in;
   logic [VALUE_WIDTH-1:0]   lo_ff, lo_in;
   logic [SPAN_WIDTH-1:0]    span_ff, span_in;
   logic [VALUE_WIDTH-1:0]   rsp_data_ff, rsp_data_in;

   logic                     csr_write;
   logic [63:0]              cnt_ext;
   logic signed [VALUE_WIDTH-1:0] lo_sel;
   logic signed [VALUE_WIDTH-1:0] hi_sel;
   logic [31:0]              frame_sel;
   logic [63:0]              pre_sum;
   logic [63:0]              mix_out;
   logic [63:0]              key;

   logic                     mul_start;
   logic [63:0]              mul_a;
   logic [63:0]              mul_b;
   logic                     mul_done;
   logic [63:0]              mul_prod;
   logic                     div_start;
   logic                     div_done;
   logic [SPAN_WIDTH-1:0]    div_rem;

   // Register port: writes complete on the access cycle
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      object_id_in = object_id_ff;
      frame_reg_in = frame_reg_ff;
      if (csr_write) begin
         case (csr_paddr[3])
            krr_pkg::REG_OBJECT_ID:     object_id_in = csr_pwdata;
            krr_pkg::REG_DEFAULT_FRAME: frame_reg_in = csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3])
         krr_pkg::REG_OBJECT_ID:     csr_prdata = object_id_ff;
         krr_pkg::REG_DEFAULT_FRAME: csr_prdata = {32'h0, frame_reg_ff};
         default:                    csr_prdata = '0;
      endcase
   end

   // Counter widened for the key add
   always_comb begin
      cnt_ext = '0;
      cnt_ext[COUNTER_WIDTH-1:0] = cnt_ff;
   end

   // Order the bounds and pick the frame on accept
   always_comb begin
      if (req_low_bound > req_high_bound) begin
         lo_sel = req_high_bound;
         hi_sel = req_low_bound;
      end else begin
         lo_sel = req_low_bound;
         hi_sel = req_high_bound;
      end
      frame_sel = req_has_frame ? req_frame_value : frame_reg_ff;
   end

   // Hash pieces around the multiplies
   assign pre_sum = z_ff + krr_pkg::GOLDEN;
   assign mix_out = mul_prod ^ (mul_prod >> 31);
   assign key     = mix_out ^ hold_ff;

   // Sequencer: next state and datapath controls
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      seeded_in    = seeded_ff;
      z_in         = z_ff;
      fr_in        = fr_ff;
      hold_in      = hold_ff;
      lo_in        = lo_ff;
      span_in      = span_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      mul_start    = 1'b0;
      mul_a        = pre_sum ^ (pre_sum >> 30);
      mul_b        = krr_pkg::MULT_A;
      div_start    = 1'b0;
      req_ready    = 1'b0;
      case (state_ff)
         krr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               seeded_in = req_use_seed;
               z_in      = req_use_seed ? req_seed_value : object_id_ff;
               fr_in     = {{32{frame_sel[31]}}, frame_sel} + krr_pkg::FRAME_SALT;
               lo_in     = lo_sel;
               span_in   = {hi_sel[VALUE_WIDTH-1], hi_sel}
                         - {lo_sel[VALUE_WIDTH-1], lo_sel} + SPAN_WIDTH'(1);
               phase_in  = krr_pkg::PH_SEED;
               state_in  = krr_pkg::ST_PRE;
            end
         end
         // add the golden step, fold, and start the first multiply
         krr_pkg::ST_PRE: begin
            mul_start = 1'b1;
            state_in  = krr_pkg::ST_MUL_A;
         end
         // fold the first product and start the second multiply
         krr_pkg::ST_MUL_A: begin
            mul_a = mul_prod ^ (mul_prod >> 27);
            mul_b = krr_pkg::MULT_B;
            if (mul_done) begin
               mul_start = 1'b1;
               state_in  = krr_pkg::ST_MUL_B;
            end
         end
         // finish the pass and pick what follows
         krr_pkg::ST_MUL_B: begin
            if (mul_done) begin
               state_in = krr_pkg::ST_PRE;
               case (phase_ff)
                  krr_pkg::PH_SEED: begin
                     hold_in  = mix_out;
                     z_in     = fr_ff;
                     phase_in = krr_pkg::PH_FRAME;
                  end
                  krr_pkg::PH_FRAME: begin
                     if (seeded_ff) begin
                        z_in     = key;
                        phase_in = krr_pkg::PH_FINAL;
                     end else begin
                        z_in     = key + cnt_ext;
                        cnt_in   = cnt_ff + COUNTER_WIDTH'(1);
                        phase_in = krr_pkg::PH_COUNT;
                     end
                  end
                  krr_pkg::PH_COUNT: begin
                     z_in     = mix_out;
                     phase_in = krr_pkg::PH_FINAL;
                  end
                  default: begin
                     div_start = 1'b1;
                     state_in  = krr_pkg::ST_DIV;
                  end
               endcase
            end
         end
         krr_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = krr_pkg::ST_SUM;
            end
         end
         // offset the remainder by the low bound once the output is free
         krr_pkg::ST_SUM: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = lo_ff + div_rem[VALUE_WIDTH-1:0];
               rsp_valid_in = 1'b1;
               state_in     = krr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = krr_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= krr_pkg::ST_IDLE;
         phase_ff     <= krr_pkg::PH_SEED;
         cnt_ff       <= '0;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         object_id_ff <= '0;
         frame_reg_ff <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
         object_id_ff <= object_id_in;
         frame_reg_ff <= frame_reg_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      z_ff        <= z_in;
      fr_ff       <= fr_in;
      hold_ff     <= hold_in;
      lo_ff       <= lo_in;
      span_ff     <= span_in;
      rsp_data_ff <= rsp_data_in;
   end

   krr_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   krr_div #(
      .DIV_WIDTH (SPAN_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (mix_out),
      .divisor   (span_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_data_ff;

endmodule
